[rtl/core/ultrasonic_presence_servo_ramp_macros.svh]
// Assertion macros for the ultrasonic presence servo ramp RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ULTRASONIC_PRESENCE_SERVO_RAMP_MACROS_SVH
`define ULTRASONIC_PRESENCE_SERVO_RAMP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define USPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication in same cycle");
// next-cycle implication, checked outside reset
`define USPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: implication in next cycle");
`else
`define USPS_ASSERT_NOW(label, clk, rstn, ante, cons)
`define USPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/usps_pkg.sv]
// Package for the ultrasonic presence servo ramp: item structs, register
// indexes and field widths. No dependencies.
package usps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIGGER_DISTANCE = 3'd0,
        CFG_REQUIRED_RUN     = 3'd1,
        CFG_SERVO_STEP       = 3'd2,
        CFG_SERVO_MIN        = 3'd3,
        CFG_SERVO_MAX        = 3'd4,
        CFG_TRIGGER_PERIOD   = 3'd5
    } cfg_index_t;

    localparam logic [7:0]  TRIGGER_DISTANCE_RST = 8'd100;
    localparam logic [3:0]  REQUIRED_RUN_RST     = 4'd6;
    localparam logic [7:0]  SERVO_STEP_RST       = 8'd3;
    localparam logic [15:0] SERVO_MIN_RST        = 16'd1000;
    localparam logic [15:0] SERVO_MAX_RST        = 16'd2000;
    localparam logic [15:0] TRIGGER_PERIOD_RST   = 16'd300;

    localparam logic [7:0]  DISTANCE_SAT = 8'd255;

    typedef struct packed {
        logic echo_level;
        logic cm_tick;
        logic ms_tick;
        logic manual_open;
    } in_item_t;

    typedef struct packed {
        logic        trigger_out;
        logic [15:0] servo_position;
        logic        reading_done;
        logic [7:0]  distance_cm;
        logic        presence;
    } out_item_t;

endpackage

[rtl/core/ultrasonic_presence_servo_ramp.sv]
// Top level of the ultrasonic presence servo ramp.
// Depends on usps_pkg and ultrasonic_presence_servo_ramp_macros.svh.
//
// Usage:
//   s_valid/s_ready/s_item carry one sampled item per handshake: echo level,
//   centimetre and millisecond strobes, manual-open level.
//   m_valid/m_ready/m_item return exactly one result item per input item:
//   trigger level, servo position, reading-done flag, last distance, presence.
//   cfg_wr_en/cfg_index/cfg_wr_data write one register per cycle, no wait;
//   write only while no item is in flight.
//   Each result is registered into the output buffer and shown on m_item from there.
//   Throughput: one item per cycle while s_ready is high; the echo, range and
//   servo state is updated in the same cycle the item is taken, by counters and compares.
//   Results go into a two-entry output buffer (main register plus skid), so an
//   item is still taken while one result waits; s_ready drops only when both
//   entries are full, and rises again once m_ready drains one.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   the range state, sets the run counter to six, parks the servo at 1000
//   and empties the output buffer.
`include "ultrasonic_presence_servo_ramp_macros.svh"

module ultrasonic_presence_servo_ramp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [usps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [usps_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  usps_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output usps_pkg::out_item_t                 m_item
);
    import usps_pkg::*;

    // configuration registers
    logic [7:0]  trig_dist_reg;
    logic [3:0]  req_run_reg;
    logic [7:0]  step_reg;
    logic [15:0] servo_min_reg;
    logic [15:0] servo_max_reg;
    logic [15:0] period_reg;

    // range and servo state
    logic        echo_prev_reg,  echo_prev_next;
    logic        timing_reg,     timing_next;
    logic [7:0]  dist_cnt_reg,   dist_cnt_next;
    logic [7:0]  last_dist_reg,  last_dist_next;
    logic [3:0]  run_left_reg,   run_left_next;
    logic [15:0] servo_reg,      servo_next;
    logic [15:0] phase_reg,      phase_next;
    logic        trig_lvl_reg,   trig_lvl_next;

    // output buffer
    out_item_t   main_reg, skid_reg;
    logic        main_valid_reg, skid_valid_reg;

    logic        s_accept, m_pop;
    logic        echo_rise, echo_fall, far_reading, open_req;
    logic [7:0]  dist_edge;
    logic        timing_edge;
    logic [16:0] phase_inc, servo_up, servo_floor;
    out_item_t   result;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = main_valid_reg;
    assign m_item   = main_reg;
    assign m_pop    = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_dist_reg <= TRIGGER_DISTANCE_RST;
            req_run_reg   <= REQUIRED_RUN_RST;
            step_reg      <= SERVO_STEP_RST;
            servo_min_reg <= SERVO_MIN_RST;
            servo_max_reg <= SERVO_MAX_RST;
            period_reg    <= TRIGGER_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRIGGER_DISTANCE: trig_dist_reg <= cfg_wr_data[7:0];
                CFG_REQUIRED_RUN:     req_run_reg   <= cfg_wr_data[3:0];
                CFG_SERVO_STEP:       step_reg      <= cfg_wr_data[7:0];
                CFG_SERVO_MIN:        servo_min_reg <= cfg_wr_data;
                CFG_SERVO_MAX:        servo_max_reg <= cfg_wr_data;
                CFG_TRIGGER_PERIOD:   period_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        echo_rise   = s_item.echo_level && !echo_prev_reg;
        echo_fall   = !s_item.echo_level && echo_prev_reg;
        far_reading = dist_cnt_reg >= trig_dist_reg;
        open_req    = 1'b0;

        echo_prev_next = s_item.echo_level;
        last_dist_next = last_dist_reg;
        run_left_next  = run_left_reg;
        dist_edge      = dist_cnt_reg;
        timing_edge    = timing_reg;

        // echo edge first
        if (echo_rise) begin
            timing_edge = 1'b1;
            dist_edge   = '0;
        end else if (echo_fall) begin
            timing_edge    = 1'b0;
            last_dist_next = dist_cnt_reg;
            if (far_reading) begin
                run_left_next = req_run_reg;
            end else if (run_left_reg != '0) begin
                run_left_next = run_left_reg - 4'd1;
            end
        end

        // then the centimetre tick
        dist_cnt_next = dist_edge;
        timing_next   = timing_edge;
        if (s_item.cm_tick && timing_edge) begin
            if (dist_edge != DISTANCE_SAT) begin
                dist_cnt_next = dist_edge + 8'd1;
            end
            if (dist_cnt_next >= trig_dist_reg) begin
                timing_next = 1'b0;
            end
        end

        // then the millisecond tick
        phase_inc   = {1'b0, phase_reg} + 17'd1;
        servo_up    = {1'b0, servo_reg} + {9'd0, step_reg};
        servo_floor = {1'b0, servo_min_reg} + {9'd0, step_reg};
        phase_next    = phase_reg;
        trig_lvl_next = trig_lvl_reg;
        servo_next    = servo_reg;
        if (s_item.ms_tick) begin
            if (phase_inc >= {1'b0, period_reg}) begin
                phase_next    = '0;
                trig_lvl_next = 1'b1;
            end else begin
                phase_next    = phase_inc[15:0];
                trig_lvl_next = 1'b0;
            end
            open_req = s_item.manual_open || (run_left_next == '0);
            if (open_req) begin
                // hold at the top instead of overshooting
                if (servo_up < {1'b0, servo_max_reg}) begin
                    servo_next = servo_up[15:0];
                end
            end else if ({1'b0, servo_reg} > servo_floor) begin
                servo_next = servo_reg - {8'd0, step_reg};
            end
        end

        result.trigger_out    = trig_lvl_next;
        result.servo_position = servo_next;
        result.reading_done   = echo_fall;
        result.distance_cm    = last_dist_next;
        result.presence       = (run_left_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg <= 1'b0;
            timing_reg    <= 1'b0;
            dist_cnt_reg  <= '0;
            last_dist_reg <= '0;
            run_left_reg  <= REQUIRED_RUN_RST;
            servo_reg     <= SERVO_MIN_RST;
            phase_reg     <= '0;
            trig_lvl_reg  <= 1'b0;
        end else if (s_accept) begin
            echo_prev_reg <= echo_prev_next;
            timing_reg    <= timing_next;
            dist_cnt_reg  <= dist_cnt_next;
            last_dist_reg <= last_dist_next;
            run_left_reg  <= run_left_next;
            servo_reg     <= servo_next;
            phase_reg     <= phase_next;
            trig_lvl_reg  <= trig_lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= s_accept;
                if (s_accept) begin
                    main_reg <= result;
                end
            end
        end else if (s_accept) begin
            if (!main_valid_reg) begin
                main_reg       <= result;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // skid entry is only ever behind a full main entry
    `USPS_ASSERT_NOW(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    // a waiting skid result is not dropped while the receiver stalls
    `USPS_ASSERT_NEXT(a_skid_kept, aclk, aresetn, skid_valid_reg && !m_ready, skid_valid_reg)
    // far reading reloads the run counter
    `USPS_ASSERT_NEXT(a_far_reload, aclk, aresetn, s_accept && echo_fall && far_reading,
        run_left_reg == $past(req_run_reg))
    // servo moves only on a millisecond tick
    `USPS_ASSERT_NEXT(a_servo_still, aclk, aresetn, s_accept && !s_item.ms_tick,
        servo_reg == $past(servo_reg))

endmodule
